// ----- rtl/lpc_pkg.sv -----
// Shared types, constants and the LFSR step function for the LFSR pattern checker.
// No dependencies; every other file refers to it by scoped names.
package lpc_pkg;

    localparam int SAMPLE_W = 16;

    localparam logic [SAMPLE_W-1:0] SEED_RESET = 16'hABCD;

    // Feedback taps, XNOR-combined and shifted in at the top bit.
    localparam int TAP_A = 0;
    localparam int TAP_B = 1;
    localparam int TAP_C = 3;
    localparam int TAP_D = 12;
    localparam int TOP_BIT = 15;

    typedef struct packed {
        logic [SAMPLE_W-1:0] expected_value;
        logic [SAMPLE_W-1:0] match_count;
        logic [SAMPLE_W-1:0] sample_count;
        logic                all_match;
    } t_result;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_first;
        logic [SAMPLE_W-1:0] sample_second;
        logic                last_word;
    } t_word;

    function automatic logic [SAMPLE_W-1:0] lfsr_next(input logic [SAMPLE_W-1:0] v);
        logic fb;
        fb = ~(v[TAP_A] ^ v[TAP_B] ^ v[TAP_C] ^ v[TAP_D]);
        return {fb, v[TOP_BIT:1]};
    endfunction

endpackage

// ----- rtl/lpc_if.sv -----
// Valid/ready stream interfaces for the LFSR pattern checker: word requests in,
// result requests out. Depends on lpc_pkg for the field width.
interface lpc_word_if;
    logic                          valid;
    logic                          ready;
    logic [lpc_pkg::SAMPLE_W-1:0]  sample_first;
    logic [lpc_pkg::SAMPLE_W-1:0]  sample_second;
    logic                          last_word;

    modport source (output valid, output sample_first, output sample_second,
                    output last_word, input ready);
    modport sink   (input valid, input sample_first, input sample_second,
                    input last_word, output ready);
endinterface

interface lpc_result_if;
    logic                          valid;
    logic                          ready;
    logic [lpc_pkg::SAMPLE_W-1:0]  expected_value;
    logic [lpc_pkg::SAMPLE_W-1:0]  match_count;
    logic [lpc_pkg::SAMPLE_W-1:0]  sample_count;
    logic                          all_match;

    modport source (output valid, output expected_value, output match_count,
                    output sample_count, output all_match, input ready);
    modport sink   (input valid, input expected_value, input match_count,
                    input sample_count, input all_match, output ready);
endinterface

// ----- rtl/lpc_eval.sv -----
// Compare and tally logic for one captured word: result and next checker state.
// Depends on lpc_pkg (types, LFSR step).
module lpc_eval #(
    parameter int COUNT_WIDTH = 16
) (
    input  lpc_pkg::t_word                    i_word,
    input  logic [lpc_pkg::SAMPLE_W-1:0]      i_gen,
    input  logic [COUNT_WIDTH-1:0]            i_good,
    input  logic [COUNT_WIDTH-1:0]            i_seen,
    input  logic                              i_miss,
    output lpc_pkg::t_result                  o_result,
    output logic [lpc_pkg::SAMPLE_W-1:0]      o_gen,
    output logic [COUNT_WIDTH-1:0]            o_good,
    output logic [COUNT_WIDTH-1:0]            o_seen,
    output logic                              o_miss
);

    localparam logic [COUNT_WIDTH-1:0] TALLY_MAX = {COUNT_WIDTH{1'b1}};

    logic                 hit_a;
    logic                 hit_b;
    logic                 word_miss;
    logic [COUNT_WIDTH:0] good_sum;
    logic [COUNT_WIDTH:0] seen_sum;
    logic [COUNT_WIDTH-1:0] good_sat;
    logic [COUNT_WIDTH-1:0] seen_sat;

    always_comb begin
        hit_a     = (i_word.sample_first  == i_gen);
        hit_b     = (i_word.sample_second == i_gen);
        word_miss = ~(hit_a & hit_b);

        good_sum = {1'b0, i_good} + (COUNT_WIDTH+1)'(hit_a) + (COUNT_WIDTH+1)'(hit_b);
        seen_sum = {1'b0, i_seen} + (COUNT_WIDTH+1)'(2);
        good_sat = (good_sum > {1'b0, TALLY_MAX}) ? TALLY_MAX : good_sum[COUNT_WIDTH-1:0];
        seen_sat = (seen_sum > {1'b0, TALLY_MAX}) ? TALLY_MAX : seen_sum[COUNT_WIDTH-1:0];

        o_result.expected_value = i_gen;
        o_result.match_count    = lpc_pkg::SAMPLE_W'(good_sat);
        o_result.sample_count   = lpc_pkg::SAMPLE_W'(seen_sat);
        o_result.all_match      = ~(i_miss | word_miss);

        o_gen = lpc_pkg::lfsr_next(i_gen);
        // End of capture: report first, then clear tallies and the sticky miss.
        if (i_word.last_word) begin
            o_good = '0;
            o_seen = '0;
            o_miss = 1'b0;
        end else begin
            o_good = good_sat;
            o_seen = seen_sat;
            o_miss = i_miss | word_miss;
        end
    end

endmodule

// ----- rtl/lfsr_pattern_checker.sv -----
// Top level of the LFSR pattern checker: input register, checker state, result register.
// Depends on lpc_pkg, lpc_if.sv (stream interfaces) and lpc_eval.
//
// Usage:
//   i_word carries one captured 32-bit word per request: two 16-bit samples and a
//   last_word flag. o_result returns one request per word: the LFSR value both
//   samples were compared with, the saturating match and sample counts of the
//   current capture, and an all-match flag.
//   A word is taken when valid and ready are high at a rising edge. It sits in
//   the input register, is checked against the generator there, and the result is
//   registered in the result register, from which the receiver takes it. Throughput
//   is one word per cycle while the receiver does not stall; the LFSR step, two
//   16-bit compares and the COUNT_WIDTH-bit saturating adders form the only logic
//   between the two registers.
//   When the receiver stalls, the result register holds, then the input register
//   fills and i_word.ready drops; nothing is lost or repeated.
//   Reset (synchronous, active low) empties both registers, loads the generator
//   with 0xABCD and clears the counts. A write on i_cfg_we reloads the generator
//   with the seed; the counts are kept. Write the seed only while idle.
module lfsr_pattern_checker #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lpc_pkg::SAMPLE_W-1:0]  i_cfg_wdata,
    lpc_word_if.sink                      i_word,
    lpc_result_if.source                  o_result
);

    // Input register
    logic              r_in_valid;
    lpc_pkg::t_word    r_in_word;
    // Result register
    logic              r_out_valid;
    lpc_pkg::t_result  r_out;
    // Checker state
    logic [lpc_pkg::SAMPLE_W-1:0] r_gen;
    logic [COUNT_WIDTH-1:0]       r_good;
    logic [COUNT_WIDTH-1:0]       r_seen;
    logic                         r_miss;

    lpc_pkg::t_result             n_out;
    logic [lpc_pkg::SAMPLE_W-1:0] n_gen;
    logic [COUNT_WIDTH-1:0]       n_good;
    logic [COUNT_WIDTH-1:0]       n_seen;
    logic                         n_miss;

    logic out_free;
    logic in_free;
    logic in_take;
    logic in_move;

    // The result slot frees when empty or taken this cycle; the input slot frees
    // when empty or moving on into the result slot.
    assign out_free = ~r_out_valid | o_result.ready;
    assign in_move  = r_in_valid & out_free;
    assign in_free  = ~r_in_valid | out_free;
    assign in_take  = i_word.valid & in_free;

    assign i_word.ready = in_free;

    lpc_eval #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_eval (
        .i_word   (r_in_word),
        .i_gen    (r_gen),
        .i_good   (r_good),
        .i_seen   (r_seen),
        .i_miss   (r_miss),
        .o_result (n_out),
        .o_gen    (n_gen),
        .o_good   (n_good),
        .o_seen   (n_seen),
        .o_miss   (n_miss)
    );

    // Control state and checker state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_gen       <= lpc_pkg::SEED_RESET;
            r_good      <= '0;
            r_seen      <= '0;
            r_miss      <= 1'b0;
        end else begin
            if (in_free) begin
                r_in_valid <= i_word.valid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (in_move) begin
                r_good <= n_good;
                r_seen <= n_seen;
                r_miss <= n_miss;
            end
            // Seed write: reload the generator, keep the tallies.
            if (i_cfg_we) begin
                r_gen <= i_cfg_wdata;
            end else if (in_move) begin
                r_gen <= n_gen;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word.sample_first  <= i_word.sample_first;
            r_in_word.sample_second <= i_word.sample_second;
            r_in_word.last_word     <= i_word.last_word;
        end
        if (in_move) begin
            r_out <= n_out;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.expected_value = r_out.expected_value;
    assign o_result.match_count    = r_out.match_count;
    assign o_result.sample_count   = r_out.sample_count;
    assign o_result.all_match      = r_out.all_match;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for lfsr_pattern_checker: drives word requests, predicts each result.
// Depends on rtl/lpc_pkg.sv, rtl/lpc_if.sv and rtl/lfsr_pattern_checker.sv.
module testbench;

    typedef logic [lpc_pkg::SAMPLE_W-1:0] t_sample;

    // Tally width of the instance; the predictor saturates at the same point.
    localparam int      TALLY_W       = 16;
    localparam longint  TALLY_MAX     = (64'd1 << TALLY_W) - 1;
    localparam int      CLK_HALF_NS   = 10;
    localparam int      RESET_CYCLES  = 8;
    // Padding after draining, past the input register and the result register.
    localparam int      SETTLE_CYCLES = 4;
    localparam int      RANDOM_WORDS  = 160;
    localparam int      LONG_HOLD     = 200;
    // Closing capture sent with no idling on either side.
    localparam int      STEADY_WORDS  = 20;
    localparam int      MAX_REPORTS   = 40;
    // Slowest correct run is well under 2 ms; allow many times that.
    localparam longint  LIMIT_NS      = 64'd20_000_000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    t_sample i_cfg_wdata;

    lpc_word_if   word_bus ();
    lpc_result_if result_bus ();

    lfsr_pattern_checker #(
        .COUNT_WIDTH (TALLY_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_word      (word_bus),
        .o_result    (result_bus)
    );

    // ------------------------------------------------------------------
    // Predictor state: mirror of the generator, the capture tallies and
    // the sticky mismatch flag of the current capture.
    // ------------------------------------------------------------------
    t_sample             lfsr_ref;
    logic [TALLY_W-1:0]  match_tally;
    logic [TALLY_W-1:0]  checked_tally;
    logic                capture_missed;

    // Results predicted at word acceptance, oldest first.
    lpc_pkg::t_result pending_results[$];

    int  n_errors;
    int  words_sent;
    int  captures_done;
    int  seeds_loaded;
    int  results_checked;

    // Shared with the receiver process.
    bit  idle_enabled;
    int  hold_request;

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // Advance the reference LFSR: XNOR of taps 0, 1, 3 and 12 enters at the top.
    function automatic t_sample lfsr_advance(input t_sample v);
        logic fb;
        fb = ~^(v & 16'h100B);
        return {fb, v[lpc_pkg::SAMPLE_W-1:1]};
    endfunction

    function automatic logic [TALLY_W-1:0] sat_add(input logic [TALLY_W-1:0] a, input int b);
        longint sum;
        sum = longint'(a) + b;
        return (sum > TALLY_MAX) ? TALLY_MAX[TALLY_W-1:0] : sum[TALLY_W-1:0];
    endfunction

    // Work out the result of one accepted word and update the mirrored state.
    function automatic lpc_pkg::t_result check_word(input t_sample s_first,
                                                    input t_sample s_second,
                                                    input logic last);
        lpc_pkg::t_result res;
        int               hits;
        hits = 0;
        if (s_first == lfsr_ref) hits++;
        if (s_second == lfsr_ref) hits++;
        if (hits != 2) capture_missed = 1'b1;
        match_tally   = sat_add(match_tally, hits);
        checked_tally = sat_add(checked_tally, 2);
        res.expected_value = lfsr_ref;
        res.match_count    = match_tally[lpc_pkg::SAMPLE_W-1:0];
        res.sample_count   = checked_tally[lpc_pkg::SAMPLE_W-1:0];
        res.all_match      = ~capture_missed;
        lfsr_ref = lfsr_advance(lfsr_ref);
        // End of capture: report first, then clear; the generator runs on.
        if (last) begin
            match_tally    = '0;
            checked_tally  = '0;
            capture_missed = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Called at a rising edge; returns at the edge where the
    // request was taken. Valid stays high so back-to-back words need no
    // second assignment in the same step.
    // ------------------------------------------------------------------
    task automatic send_word(input t_sample s_first, input t_sample s_second, input logic last);
        word_bus.valid         <= 1'b1;
        word_bus.sample_first  <= s_first;
        word_bus.sample_second <= s_second;
        word_bus.last_word     <= last;
        do @(posedge i_clk); while (word_bus.ready !== 1'b1);
        pending_results.push_back(check_word(s_first, s_second, last));
        words_sent++;
        if (last) captures_done++;
    endtask

    // Drop valid for a random burst now and then.
    task automatic sender_gap();
        if (idle_enabled && $urandom_range(0, 99) < 15) begin
            word_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Hold off new words until every predicted result has come back.
    task automatic wait_drained();
        word_bus.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Reload the generator; only done with the block idle.
    task automatic load_seed(input t_sample seed);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= seed;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        lfsr_ref = seed;
        seeds_loaded++;
    endtask

    // The expected value (mostly, when mostly_good is set), sometimes one flipped bit, sometimes noise.
    function automatic t_sample pick_sample(input bit mostly_good);
        int r;
        r = $urandom_range(0, 99);
        if (r < (mostly_good ? 85 : 25)) return lfsr_ref;
        if (r < (mostly_good ? 93 : 60)) return lfsr_ref ^ (16'h1 << $urandom_range(0, 15));
        if (r < 96) return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        return t_sample'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Generator starts from its reset seed; hit every compare outcome, the
    // field extremes, a capture end and the clear that follows it.
    task automatic test_reset_seed();
        send_word(lfsr_ref, lfsr_ref, 1'b0);
        send_word(lfsr_ref, 16'h0000, 1'b0);
        send_word(16'hFFFF, lfsr_ref, 1'b0);
        send_word(16'h0000, 16'hFFFF, 1'b1);
        send_word(lfsr_ref, lfsr_ref, 1'b0);
        send_word(lfsr_ref, lfsr_ref, 1'b1);
        send_word(lfsr_ref, lfsr_ref, 1'b1);
    endtask

    // Seed extremes, including the all-ones lock-up state, and a reload in
    // the middle of a capture that must leave the tallies alone.
    task automatic test_seed_loads();
        load_seed(16'h0000);
        send_word(lfsr_ref, lfsr_ref, 1'b0);
        send_word(lfsr_ref, 16'h0000, 1'b0);
        send_word(lfsr_ref, lfsr_ref, 1'b1);
        load_seed(16'hFFFF);
        send_word(16'hFFFF, 16'hFFFF, 1'b0);
        send_word(lfsr_ref, 16'hFFFE, 1'b0);
        send_word(lfsr_ref, lfsr_ref, 1'b1);
        send_word(lfsr_ref, 16'h1234, 1'b0);
        send_word(lfsr_ref, lfsr_ref, 1'b0);
        load_seed(16'h8001);
        send_word(lfsr_ref, lfsr_ref, 1'b0);
        send_word(lfsr_ref, lfsr_ref, 1'b1);
    endtask

    // Captures of random length and content with random idling on both sides
    // and an occasional reseed between captures.
    task automatic test_random_captures();
        int  goal;
        int  len;
        bit  mostly_good;
        bit  quiet;
        bit  was_idle;
        goal = words_sent + RANDOM_WORDS;
        was_idle = idle_enabled;
        while (words_sent < goal) begin
            len         = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 40);
            mostly_good = $urandom_range(0, 9) != 0;
            quiet       = $urandom_range(0, 3) == 0;
            if ($urandom_range(0, 5) == 0) load_seed(t_sample'($urandom));
            idle_enabled = was_idle && !quiet;
            for (int i = 0; i < len; i++) begin
                send_word(pick_sample(mostly_good), pick_sample(mostly_good), i == len - 1);
                sender_gap();
            end
        end
        idle_enabled = was_idle;
    endtask

    // Stall the receiver for a long stretch while words keep coming, so the
    // block fills and drops its input ready; then pause until it drains.
    task automatic test_backpressure();
        word_bus.valid <= 1'b0;
        hold_request = LONG_HOLD;
        do @(posedge i_clk); while (hold_request != 0);
        for (int i = 0; i < 30; i++)
            send_word(pick_sample(1'b1), pick_sample(1'b1), i == 29);
        wait_drained();
    endtask

    // Closing capture with both sides always ready; a late mismatch must
    // clear the all-match flag for the rest of the capture.
    task automatic test_steady_stream();
        idle_enabled = 1'b0;
        for (int i = 0; i < STEADY_WORDS; i++)
            send_word(lfsr_ref, lfsr_ref, 1'b0);
        send_word(lfsr_ref, ~lfsr_ref, 1'b0);
        send_word(lfsr_ref, lfsr_ref, 1'b0);
        send_word(lfsr_ref, lfsr_ref, 1'b1);
        send_word(lfsr_ref, lfsr_ref, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_clk                  = 1'b0;
        i_rst_n                <= 1'b0;
        i_cfg_we               <= 1'b0;
        i_cfg_wdata            <= '0;
        word_bus.valid         <= 1'b0;
        word_bus.sample_first  <= '0;
        word_bus.sample_second <= '0;
        word_bus.last_word     <= 1'b0;
        lfsr_ref       = lpc_pkg::SEED_RESET;
        match_tally    = '0;
        checked_tally  = '0;
        capture_missed = 1'b0;
        n_errors        = 0;
        words_sent      = 0;
        captures_done   = 0;
        seeds_loaded    = 0;
        results_checked = 0;
        idle_enabled    = 1'b1;
        hold_request    = 0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_seed();
        test_seed_loads();
        test_random_captures();
        test_backpressure();
        test_random_captures();
        test_steady_stream();
        wait_drained();

        $display("Covered %0d words in %0d captures, %0d seed loads, a %0d-cycle output stall",
                 words_sent, captures_done, seeds_loaded, LONG_HOLD);
        $display("and a closing stretch with no idling; %0d results checked, %0d mismatches.",
                 results_checked, n_errors);
        if (n_errors == 0) begin
            $display("** lfsr_pattern_checker: PASSED **");
        end else begin
            $display("** lfsr_pattern_checker: FAILED **");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random ready bursts, one long hold when requested, steady
    // ready once idling is switched off.
    // ------------------------------------------------------------------
    initial begin
        int n;
        result_bus.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (hold_request > 0) begin
                n = hold_request;
                hold_request = 0;
                result_bus.ready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end else if (idle_enabled && $urandom_range(0, 99) < 20) begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end else begin
                result_bus.ready <= 1'b1;
                repeat (idle_enabled ? $urandom_range(1, 40) : 1) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each taken result with the oldest prediction.
    // Values read at the edge are the ones the block saw before it.
    // ------------------------------------------------------------------
    task automatic report_field(input string field, input int want, input int got);
        n_errors++;
        if (n_errors <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected 0x%04h, actual 0x%04h",
                     $time, field, want, got);
    endtask

    always @(posedge i_clk) begin
        lpc_pkg::t_result want;
        if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
            results_checked++;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t ns: result with none expected, actual value 0x%04h",
                             $time, result_bus.expected_value);
            end else begin
                want = pending_results.pop_front();
                if (result_bus.expected_value !== want.expected_value)
                    report_field("expected_value", want.expected_value,
                                 result_bus.expected_value);
                if (result_bus.match_count !== want.match_count)
                    report_field("match_count", want.match_count, result_bus.match_count);
                if (result_bus.sample_count !== want.sample_count)
                    report_field("sample_count", want.sample_count, result_bus.sample_count);
                if (result_bus.all_match !== want.all_match)
                    report_field("all_match", want.all_match, result_bus.all_match);
            end
        end
    end

    // Watchdog: end a hung run.
    initial begin
        #(LIMIT_NS);
        $display("Timeout at %0t ns with %0d results outstanding",
                 $time, pending_results.size());
        $display("** lfsr_pattern_checker: FAILED **");
        $finish;
    end

endmodule
